// File: src/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg: shared types and constants of the nearest-neighbor image scaler
// Item structs, opcodes, register indexes, sequencer states and divider
// request and response types.
// ----------------------------------------------------------------------------
package nnis_pkg;

  // Default sizes
  localparam int SrcMaxWidthDef  = 256;
  localparam int SrcMaxHeightDef = 256;
  localparam int DstMaxDimDef    = 4096;

  // Field widths
  localparam int COORD_W  = 12;
  localparam int PIXEL_W  = 32;
  localparam int SRC_SZ_W = 9;
  localparam int DST_SZ_W = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;

  // Width for size comparisons against parameters up to 16384
  localparam int CMP_W = 15;
  // Width for row * SRC_MAX_WIDTH + column before truncation
  localparam int ADDR_CALC_W = 26;

  // Divider: numerator = coord * src size, denominator = dst size.
  // The quotient stays below the src size, so it fits SRC_SZ_W bits.
  localparam int DIV_NUM_W = COORD_W + SRC_SZ_W;
  localparam int DIV_DEN_W = DST_SZ_W;
  localparam int DIV_QUO_W = SRC_SZ_W;
  localparam int DIV_CNT_W = $clog2(DIV_QUO_W + 1);

  localparam logic [SRC_SZ_W-1:0] SrcSizeReset = SRC_SZ_W'(256);
  localparam logic [DST_SZ_W-1:0] DstSizeReset = DST_SZ_W'(256);

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } nnis_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } nnis_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_DIV_X,
    ST_MUL_Y,
    ST_DIV_Y,
    ST_READ,
    ST_RESP
  } nnis_state_e;

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [PIXEL_W-1:0] write_pixel;
  } nnis_in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] read_pixel;
    logic               status;
  } nnis_out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } nnis_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quot;
  } nnis_div_rsp_t;

endpackage

// File: src/nearest_neighbor_image_scaler_core.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_core: frame store with nearest-neighbor read
// Write item: stored at its accept edge if inside the source size; ready again the next cycle.
// Read item: from accept to a valid result it takes two passes of the one serial
// divider (one quotient bit per cycle), the store read and the output register.
// Error reads skip the divider and the store read. Input is not ready until
// the result is registered, longer while an earlier result is held off.
// Reset sets all sizes to 256; the frame store is not cleared.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_core
  import nnis_pkg::*;
#(
  parameter int SRC_MAX_WIDTH  = SrcMaxWidthDef,
  parameter int SRC_MAX_HEIGHT = SrcMaxHeightDef,
  parameter int DST_MAX_DIM    = DstMaxDimDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  nnis_in_item_t        in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output nnis_out_item_t       out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int StoreDepth = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  // Configuration
  logic [SRC_SZ_W-1:0] src_w_q, src_h_q;
  logic [DST_SZ_W-1:0] dst_w_q, dst_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SrcSizeReset;
      src_h_q <= SrcSizeReset;
      dst_w_q <= DstSizeReset;
      dst_h_q <= DstSizeReset;
    end else if (cfg_we_i) begin
      case (nnis_cfg_e'(cfg_idx_i))
        CFG_SRC_WIDTH:  src_w_q <= cfg_wdata_i[SRC_SZ_W-1:0];
        CFG_SRC_HEIGHT: src_h_q <= cfg_wdata_i[SRC_SZ_W-1:0];
        CFG_DST_WIDTH:  dst_w_q <= cfg_wdata_i[DST_SZ_W-1:0];
        CFG_DST_HEIGHT: dst_h_q <= cfg_wdata_i[DST_SZ_W-1:0];
        default: ;
      endcase
    end
  end

  logic src_ok, dst_ok;
  assign src_ok = (src_w_q != '0) && (CMP_W'(src_w_q) <= CMP_W'(SRC_MAX_WIDTH)) &&
                  (src_h_q != '0) && (CMP_W'(src_h_q) <= CMP_W'(SRC_MAX_HEIGHT));
  assign dst_ok = (dst_w_q != '0) && (CMP_W'(dst_w_q) <= CMP_W'(DST_MAX_DIM)) &&
                  (dst_h_q != '0) && (CMP_W'(dst_h_q) <= CMP_W'(DST_MAX_DIM));

  // Sequencer state
  nnis_state_e          state_q, state_d;
  logic                 err_q, err_d;
  logic [COORD_W-1:0]   x_q, x_d, y_q, y_d;
  logic [SRC_SZ_W-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic                 out_valid_q, out_valid_d;
  nnis_out_item_t       out_item_q, out_item_d;

  logic                 in_acc;
  logic                 wr_hit, rd_err;
  logic [ADDR_CALC_W-1:0] waddr_full, raddr_full;
  logic                 ram_re;
  logic [PIXEL_W-1:0]   ram_rdata;
  logic [COORD_W-1:0]   mul_a;
  logic [SRC_SZ_W-1:0]  mul_b;
  logic [SRC_SZ_W-1:0]  src_lim;
  logic [SRC_SZ_W-1:0]  clamped;
  nnis_div_req_t        div_req;
  nnis_div_rsp_t        div_rsp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign wr_hit = in_acc && (in_item_i.opcode == OP_WRITE) && src_ok &&
                  (in_item_i.coord_x < COORD_W'(src_w_q)) &&
                  (in_item_i.coord_y < COORD_W'(src_h_q));
  assign rd_err = !src_ok || !dst_ok ||
                  ({1'b0, in_item_i.coord_x} >= dst_w_q) ||
                  ({1'b0, in_item_i.coord_y} >= dst_h_q);

  assign waddr_full = ADDR_CALC_W'(in_item_i.coord_y) * ADDR_CALC_W'(SRC_MAX_WIDTH) +
                      ADDR_CALC_W'(in_item_i.coord_x);
  assign raddr_full = ADDR_CALC_W'(sy_q) * ADDR_CALC_W'(SRC_MAX_WIDTH) +
                      ADDR_CALC_W'(sx_q);

  // one multiplier feeds the divider for both axes
  assign mul_a   = (state_q == ST_MUL_Y) ? y_q : x_q;
  assign mul_b   = (state_q == ST_MUL_Y) ? src_h_q : src_w_q;
  assign src_lim = ((state_q == ST_DIV_Y) ? src_h_q : src_w_q) - SRC_SZ_W'(1);
  assign clamped = (div_rsp.quot > src_lim) ? src_lim : div_rsp.quot;

  assign div_req.start = (state_q == ST_MUL_X) || (state_q == ST_MUL_Y);
  assign div_req.num   = DIV_NUM_W'(DIV_NUM_W'(mul_a) * DIV_NUM_W'(mul_b));
  assign div_req.den   = (state_q == ST_MUL_Y) ? dst_h_q : dst_w_q;

  assign ram_re = (state_q == ST_READ);

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    x_d         = x_q;
    y_d         = y_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_item_i.opcode == OP_READ)) begin
          x_d     = in_item_i.coord_x;
          y_d     = in_item_i.coord_y;
          err_d   = rd_err;
          state_d = rd_err ? ST_RESP : ST_MUL_X;
        end
      end
      ST_MUL_X: state_d = ST_DIV_X;
      ST_DIV_X: begin
        if (div_rsp.done) begin
          sx_d    = clamped;
          state_d = ST_MUL_Y;
        end
      end
      ST_MUL_Y: state_d = ST_DIV_Y;
      ST_DIV_Y: begin
        if (div_rsp.done) begin
          sy_d    = clamped;
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_RESP;
      ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_item_d.status     = err_q ? STATUS_ERR : STATUS_OK;
          out_item_d.read_pixel = err_q ? '0 : ram_rdata;
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q      <= err_d;
    x_q        <= x_d;
    y_q        <= y_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  nnis_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  nnis_ram #(
    .Width (PIXEL_W),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_hit),
    .waddr_i (waddr_full[AddrW-1:0]),
    .wdata_i (in_item_i.write_pixel),
    .re_i    (ram_re),
    .raddr_i (raddr_full[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

endmodule

// File: src/nnis_ram.sv
// ----------------------------------------------------------------------------
// nnis_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nnis_ram #(
  parameter int Width = 32,
  parameter int Depth = 65536,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/nnis_div.sv
// ----------------------------------------------------------------------------
// nnis_div: serial restoring divider
// One quotient bit per cycle. The numerator is known to give a quotient
// below 2**DIV_QUO_W, so the upper numerator bits seed the remainder.
// ----------------------------------------------------------------------------
module nnis_div
  import nnis_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nnis_div_req_t req_i,
  output nnis_div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_QUO_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  assign trial = {rem_q, quo_q[DIV_QUO_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      den_d  = req_i.den;
      rem_d  = DIV_DEN_W'(req_i.num[DIV_NUM_W-1:DIV_QUO_W]);
      quo_d  = req_i.num[DIV_QUO_W-1:0];
    end else if (busy_q) begin
      // shift in the next numerator bit, subtract when it fits
      rem_d = ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : DIV_DEN_W'(trial);
      quo_d = {quo_q[DIV_QUO_W-2:0], ge};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// File: src/nnis_checker.sv
// ----------------------------------------------------------------------------
// nnis_checker: port-level assertions for the image scaler core
// Watches the item channels and binds to the top level.
// ----------------------------------------------------------------------------
module nnis_checker
  import nnis_pkg::*;
(
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input nnis_in_item_t  in_item_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input nnis_out_item_t out_item_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  // an error result carries a zero pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == STATUS_ERR) |-> (out_item_o.read_pixel == '0))
    else $error("error item with nonzero pixel");

  // a read item occupies the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.opcode == OP_READ) |=> !in_ready_o)
    else $error("ready right after a read item");

  // a write item never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.opcode == OP_WRITE) |=> in_ready_o)
    else $error("not ready after a write item");

endmodule

bind nearest_neighbor_image_scaler_core nnis_checker u_nnis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
